// ===== src/dwrp_pkg.sv =====
// dwrp_pkg: shared types and constants of the draw-without-replacement picker
// used by dwrp_mod, dwrp_rank and draw_without_replacement_picker
package dwrp_pkg;

    localparam int ROLL_W    = 32;                 // roll field width
    localparam int IDX_W     = 7;                  // entry index width
    localparam int ROUND_W   = 16;                 // round counter width
    localparam int CNT_W     = 8;                  // holds a used count up to 128
    localparam int DIGIT_W   = 4;                  // bitmap bits examined per scan step
    localparam int DIG_W     = IDX_W - 2;          // digit number within the bitmap
    localparam int MOD_CNT_W = $clog2(ROLL_W);     // serial modulo step counter

    localparam logic [ROUND_W-1:0] ROUND_RESET      = 16'd1;
    localparam logic [ROUND_W-1:0] ROUND_MAX        = 16'hFFFF;
    localparam logic [ROUND_W-1:0] ROUND_AFTER_WRAP = 16'd2;

    localparam logic MODE_DRAW  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic              start;
        logic              neg;
        logic [ROLL_W-1:0] mag;
        logic [CNT_W-1:0]  div;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] rank;
    } t_mod_rsp;

    typedef struct packed {
        logic             start;
        logic [IDX_W-1:0] rank;
    } t_rank_req;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] index;
    } t_rank_rsp;

endpackage

// ===== src/draw_without_replacement_picker.sv =====
// Draw-without-replacement picker. Each input word is a draw (mode 0) or a query
// (mode 1) and gives exactly one result word. A query goes from acceptance
// straight to the result state FIN. A draw runs the bit-serial modulo of the roll
// by the unused count (one roll bit per cycle), then scans the used bitmap one
// 4-bit digit per cycle until the chosen unused entry is found; its states are
// PREP, MSTART, MWAIT, SCAN and FIN in turn. A stalled result word adds its
// stall. One word is worked on at a time; o_ready is high whenever no word is in
// progress, also while a result waits.
// When every entry is used at the start of a draw the bitmap clears and the round
// advances, wrapping from 65535 to 2.
module draw_without_replacement_picker #(
    parameter int ENTRY_COUNT = 128
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_mode,
    input  logic [dwrp_pkg::ROLL_W-1:0]  i_roll,
    input  logic [dwrp_pkg::IDX_W-1:0]   i_query_index,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [dwrp_pkg::IDX_W-1:0]   o_picked_index,
    output logic [dwrp_pkg::ROUND_W-1:0] o_round_out,
    output logic                      o_entry_used
);
    import dwrp_pkg::*;

    localparam int DIGITS = (ENTRY_COUNT + DIGIT_W - 1) / DIGIT_W;
    localparam int SCAN_W = DIGITS * DIGIT_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_MSTART = 3'd2;
    localparam logic [2:0] ST_MWAIT  = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    logic [2:0]             r_state, n_state;
    logic [ENTRY_COUNT-1:0] r_used_map, n_used_map;
    logic [CNT_W-1:0]       r_used_cnt, n_used_cnt;
    logic [ROUND_W-1:0]     r_round, n_round;
    logic [ROLL_W-1:0]      r_roll;
    logic [IDX_W-1:0]       r_res_index, n_res_index;
    logic                   r_res_used, n_res_used;
    logic                   r_out_valid, n_out_valid;
    logic [IDX_W-1:0]       r_out_index;
    logic [ROUND_W-1:0]     r_out_round;
    logic                   r_out_used;

    logic                   accept;
    logic                   query_flag;
    logic [SCAN_W-1:0]      scan_map;
    t_mod_req               mod_req;
    t_mod_rsp               mod_rsp;
    t_rank_req              rank_req;
    t_rank_rsp              rank_rsp;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    // entries past the pool read as used so the scan never lands there
    always_comb begin
        for (int i = 0; i < SCAN_W; i++) begin
            scan_map[i] = (i < ENTRY_COUNT) ? r_used_map[i % ENTRY_COUNT] : 1'b1;
        end
    end

    always_comb begin
        query_flag = 1'b0;
        for (int i = 0; i < ENTRY_COUNT; i++) begin
            if (IDX_W'(i) == i_query_index) begin
                query_flag = r_used_map[i];
            end
        end
    end

    assign mod_req.start = (r_state == ST_MSTART);
    assign mod_req.neg   = r_roll[ROLL_W-1];
    assign mod_req.mag   = r_roll[ROLL_W-1] ? (~r_roll + 1'b1) : r_roll;
    assign mod_req.div   = CNT_W'(ENTRY_COUNT) - r_used_cnt;

    assign rank_req.start = (r_state == ST_MWAIT) && mod_rsp.done;
    assign rank_req.rank  = mod_rsp.rank;

    dwrp_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    dwrp_rank #(
        .SCAN_W (SCAN_W)
    ) u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rank_req),
        .i_map   (scan_map),
        .o_rsp   (rank_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_used_map  = r_used_map;
        n_used_cnt  = r_used_cnt;
        n_round     = r_round;
        n_res_index = r_res_index;
        n_res_used  = r_res_used;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_mode == MODE_QUERY) begin
                        n_res_index = '0;
                        n_res_used  = query_flag;
                        n_state     = ST_FIN;
                    end else begin
                        n_state = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                // pool exhausted: start a new round
                if (r_used_cnt == CNT_W'(ENTRY_COUNT)) begin
                    n_used_map = '0;
                    n_used_cnt = '0;
                    n_round    = (r_round == ROUND_MAX) ? ROUND_AFTER_WRAP
                                                        : (r_round + 1'b1);
                end
                n_state = ST_MSTART;
            end
            ST_MSTART: begin
                n_state = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (mod_rsp.done) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rank_rsp.done) begin
                    for (int i = 0; i < ENTRY_COUNT; i++) begin
                        if (IDX_W'(i) == rank_rsp.index) begin
                            n_used_map[i] = 1'b1;
                        end
                    end
                    n_used_cnt  = r_used_cnt + 1'b1;
                    n_res_index = rank_rsp.index;
                    n_res_used  = 1'b0;
                    n_state     = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used_map  <= '0;
            r_used_cnt  <= '0;
            r_round     <= ROUND_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used_map  <= n_used_map;
            r_used_cnt  <= n_used_cnt;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
        r_res_index <= n_res_index;
        r_res_used  <= n_res_used;
        if (accept) begin
            r_roll <= i_roll;
        end
        if ((r_state == ST_FIN) && (!r_out_valid || i_ready)) begin
            r_out_index <= r_res_index;
            r_out_round <= r_round;
            r_out_used  <= r_res_used;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_picked_index = r_out_index;
    assign o_round_out    = r_out_round;
    assign o_entry_used   = r_out_used;

endmodule

// ===== src/dwrp_mod.sv =====
// dwrp_mod: bit-serial non-negative modulo of a signed roll by the unused count
// depends on dwrp_pkg
module dwrp_mod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dwrp_pkg::t_mod_req i_req,
    output dwrp_pkg::t_mod_rsp o_rsp
);
    import dwrp_pkg::*;

    logic [ROLL_W-1:0]    r_shift, n_shift;
    logic [CNT_W-1:0]     r_rem, n_rem;
    logic [CNT_W-1:0]     r_div;
    logic                 r_neg;
    logic [MOD_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_W:0]       trial;
    logic [CNT_W-1:0]     fixed_rem;

    always_comb begin
        n_shift = r_shift;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        // one dividend bit per cycle into the partial remainder
        trial = {r_rem, r_shift[ROLL_W-1]};
        if (trial >= {1'b0, r_div}) begin
            trial = trial - {1'b0, r_div};
        end
        if (i_req.start) begin
            n_shift = i_req.mag;
            n_rem   = '0;
            n_cnt   = '0;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            n_rem   = trial[CNT_W-1:0];
            n_shift = r_shift << 1;
            n_cnt   = r_cnt + 1'b1;
            if (r_cnt == MOD_CNT_W'(ROLL_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_shift <= n_shift;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        if (i_req.start) begin
            r_div <= i_req.div;
            r_neg <= i_req.neg;
        end
    end

    // truncated remainder of a negative roll moves up by the divisor
    assign fixed_rem  = (r_neg && (r_rem != '0)) ? (r_div - r_rem) : r_rem;
    assign o_rsp.done = r_done;
    assign o_rsp.rank = fixed_rem[IDX_W-1:0];

endmodule

// ===== src/dwrp_rank.sv =====
// dwrp_rank: finds the unused entry of a given rank, one 4-bit digit per cycle
// depends on dwrp_pkg; the bitmap is shifted out of a local copy
module dwrp_rank #(
    parameter int SCAN_W = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dwrp_pkg::t_rank_req i_req,
    input  logic [SCAN_W-1:0]  i_map,
    output dwrp_pkg::t_rank_rsp o_rsp
);
    import dwrp_pkg::*;

    logic [SCAN_W-1:0]  r_scan, n_scan;
    logic [IDX_W-1:0]   r_rank, n_rank;
    logic [DIG_W-1:0]   r_dig, n_dig;
    logic [IDX_W-1:0]   r_index, n_index;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [DIGIT_W-1:0] digit;
    logic [2:0]         free_cnt;
    logic [1:0]         seen;
    logic [1:0]         off;
    logic               found;

    assign digit = r_scan[DIGIT_W-1:0];

    always_comb begin
        free_cnt = '0;
        seen     = '0;
        off      = '0;
        found    = 1'b0;
        for (int j = 0; j < DIGIT_W; j++) begin
            if (!digit[j]) begin
                free_cnt = free_cnt + 1'b1;
                if (!found && (seen == r_rank[1:0])) begin
                    off   = 2'(j);
                    found = 1'b1;
                end
                seen = seen + 1'b1;
            end
        end
    end

    always_comb begin
        n_scan  = r_scan;
        n_rank  = r_rank;
        n_dig   = r_dig;
        n_index = r_index;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_scan = i_map;
            n_rank = i_req.rank;
            n_dig  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_rank < {{(IDX_W-3){1'b0}}, free_cnt}) begin
                n_index = {r_dig, off};
                n_busy  = 1'b0;
                n_done  = 1'b1;
            end else begin
                n_rank = r_rank - {{(IDX_W-3){1'b0}}, free_cnt};
                n_scan = r_scan >> DIGIT_W;
                n_dig  = r_dig + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_scan  <= n_scan;
        r_rank  <= n_rank;
        r_dig   <= n_dig;
        r_index <= n_index;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.index = r_index;

endmodule

// ===== src/dwrp_checker.sv =====
// dwrp_checker: port-level assertions for draw_without_replacement_picker
// depends on dwrp_pkg; attached to the top level by the bind at the end
module dwrp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         i_mode,
    input logic [dwrp_pkg::ROLL_W-1:0]  i_roll,
    input logic [dwrp_pkg::IDX_W-1:0]   i_query_index,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [dwrp_pkg::IDX_W-1:0]   o_picked_index,
    input logic [dwrp_pkg::ROUND_W-1:0] o_round_out,
    input logic                         o_entry_used
);
    import dwrp_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_picked_index)
            && $stable(o_round_out) && $stable(o_entry_used))
        else $error("result word changed while stalled");

    // one word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("accepted a word while another was in progress");

    // the round counter never shows zero
    a_round_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_round_out != '0)
        else $error("round counter reads zero");

    // a used flag only comes from a query, whose index field is zero
    a_query_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_entry_used |-> o_picked_index == '0)
        else $error("used flag with a nonzero picked index");

endmodule

bind draw_without_replacement_picker dwrp_checker u_dwrp_checker (.*);

// ===== tb/draw_without_replacement_picker_tb.sv =====
// draw_without_replacement_picker_tb: self-checking bench for the draw/query picker,
// predicting each result word from its own copy of the used bitmap and round counter
// depends on dwrp_pkg and draw_without_replacement_picker
`timescale 1ns / 1ps

module draw_without_replacement_picker_tb;
    import dwrp_pkg::*;

    localparam int POOL_SIZE    = 128;
    localparam int RANDOM_WORDS = 950;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        logic [IDX_W-1:0]   picked_index;
        logic [ROUND_W-1:0] round_out;
        logic               entry_used;
    } t_pick_result;

    // keeps the picker's state and the words it still owes
    class draw_tracker;
        bit [POOL_SIZE-1:0] used_map;
        logic [ROUND_W-1:0] cur_round;
        t_pick_result       owed_words[$];
        int                 mismatches;

        function new();
            used_map   = '0;
            cur_round  = ROUND_RESET;
            mismatches = 0;
        endfunction

        function void note_word(logic mode, logic [ROLL_W-1:0] roll, logic [IDX_W-1:0] qidx);
            t_pick_result res;
            longint       roll_s;
            longint       unused_cnt;
            longint       rem;
            int           rank;
            res.picked_index = '0;
            res.entry_used   = 1'b0;
            if (mode == MODE_DRAW) begin
                // pool exhausted: start a new round
                if (&used_map) begin
                    used_map = '0;
                    if (cur_round == ROUND_MAX)
                        cur_round = ROUND_AFTER_WRAP;
                    else
                        cur_round = cur_round + 1'b1;
                end
                unused_cnt = POOL_SIZE - $countones(used_map);
                roll_s     = $signed(roll);
                rem        = roll_s % unused_cnt;
                if (rem < 0)
                    rem = rem + unused_cnt;
                rank = int'(rem);
                for (int i = 0; i < POOL_SIZE; i++) begin
                    if (!used_map[i]) begin
                        if (rank == 0) begin
                            used_map[i]      = 1'b1;
                            res.picked_index = IDX_W'(i);
                            break;
                        end
                        rank--;
                    end
                end
            end else begin
                res.entry_used = used_map[qidx];
            end
            res.round_out = cur_round;
            owed_words.push_back(res);
        endfunction

        function void check_word(logic [IDX_W-1:0] picked, logic [ROUND_W-1:0] rnd,
                                 logic used);
            t_pick_result exp_w;
            if (owed_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: picked %0d round %0d used %0b",
                             picked, rnd, used);
                return;
            end
            exp_w = owed_words.pop_front();
            if (picked !== exp_w.picked_index || rnd !== exp_w.round_out ||
                used !== exp_w.entry_used) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: picked %0d/%0d round %0d/%0d used %0b/%0b %s",
                             $time, exp_w.picked_index, picked, exp_w.round_out, rnd,
                             exp_w.entry_used, used, "(exp/act)");
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_mode = MODE_DRAW;
    logic [ROLL_W-1:0]  i_roll = '0;
    logic [IDX_W-1:0]   i_query_index = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [IDX_W-1:0]   o_picked_index;
    logic [ROUND_W-1:0] o_round_out;
    logic               o_entry_used;

    draw_tracker tracker = new();

    draw_without_replacement_picker #(
        .ENTRY_COUNT(POOL_SIZE)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_roll        (i_roll),
        .i_query_index (i_query_index),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_picked_index(o_picked_index),
        .o_round_out   (o_round_out),
        .o_entry_used  (o_entry_used)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: switches between always ready, random stalls and long stalls
    int stall_style = 0;
    int style_left  = 0;
    int hold_left   = 0;

    always @(negedge i_clk) begin
        if (style_left == 0) begin
            stall_style = $urandom_range(0, 2);
            style_left  = $urandom_range(50, 300);
        end
        style_left--;
        case (stall_style)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (hold_left > 0) begin
                    hold_left--;
                    i_ready <= 1'b0;
                end else begin
                    i_ready <= 1'b1;
                    if ($urandom_range(0, 2) == 0)
                        hold_left = $urandom_range(1, 15);
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            tracker.check_word(o_picked_index, o_round_out, o_entry_used);
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(logic mode, logic [ROLL_W-1:0] roll, logic [IDX_W-1:0] qidx);
        i_valid       = 1'b1;
        i_mode        = mode;
        i_roll        = roll;
        i_query_index = qidx;
        do
            @(posedge i_clk);
        while (!o_ready);
        tracker.note_word(mode, roll, qidx);
        @(negedge i_clk);
    endtask

    task automatic idle_for(int cycles);
        i_valid = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (tracker.owed_words.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int               burst_left;
        logic             mode;
        logic [ROLL_W-1:0] roll;
        logic [IDX_W-1:0] qidx;

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // fresh state, field extremes, negative and extreme rolls, stray fields ignored
        send_word(MODE_QUERY, 32'h0000_0000, 7'd0);
        send_word(MODE_QUERY, 32'hFFFF_FFFF, 7'd127);
        send_word(MODE_DRAW,  32'h0000_0000, 7'd0);
        send_word(MODE_DRAW,  32'hFFFF_FFFF, 7'd127);
        send_word(MODE_DRAW,  32'h7FFF_FFFF, 7'd0);
        send_word(MODE_DRAW,  32'h8000_0000, 7'd127);
        send_word(MODE_DRAW,  32'h0000_0001, 7'd64);
        send_word(MODE_DRAW,  32'hFFFF_FF80, 7'd0);
        send_word(MODE_DRAW,  32'h0000_007C, 7'd0);
        send_word(MODE_QUERY, 32'hFFFF_FFFF, 7'd0);
        send_word(MODE_QUERY, 32'h0000_0000, 7'd127);
        send_word(MODE_QUERY, 32'h1234_5678, 7'd64);
        send_word(MODE_QUERY, 32'h0000_0000, 7'd1);
        send_word(MODE_DRAW,  32'h5555_5555, 7'h2A);
        send_word(MODE_DRAW,  32'hAAAA_AAAA, 7'h55);
        idle_for(3);
        send_word(MODE_DRAW,  32'h8000_0001, 7'd3);
        send_word(MODE_QUERY, 32'h0000_0000, 7'd126);

        // let everything come back before going random
        wait_drained();

        // mostly draws so the pool empties and the round advances several times;
        // the round wrap needs millions of draws and stays out of reach
        burst_left = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 4) == 0)
                    idle_for($urandom_range(10, 30));
                else
                    idle_for($urandom_range(0, 6));
                burst_left = $urandom_range(1, 12);
            end
            if ($urandom_range(0, 79) == 0)
                wait_drained();
            mode = ($urandom_range(0, 3) == 0) ? MODE_QUERY : MODE_DRAW;
            case ($urandom_range(0, 5))
                0, 1, 2: roll = $urandom;
                3:       roll = $urandom_range(0, 600) - 300;
                4: begin
                    case ($urandom_range(0, 4))
                        0:       roll = 32'h7FFF_FFFF;
                        1:       roll = 32'h8000_0000;
                        2:       roll = 32'hFFFF_FFFF;
                        3:       roll = 32'h0000_0000;
                        default: roll = 32'h0000_0001;
                    endcase
                end
                default: roll = $urandom_range(0, 255);
            endcase
            qidx = IDX_W'($urandom_range(0, POOL_SIZE - 1));
            send_word(mode, roll, qidx);
            burst_left--;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (tracker.mismatches == 0 && tracker.owed_words.size() == 0)
            $display("[draw_without_replacement_picker] OK");
        else
            $display("[draw_without_replacement_picker] ERROR");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("[draw_without_replacement_picker] ERROR");
        $finish;
    end

endmodule

// ===== draw_without_replacement_picker.f =====
src/dwrp_pkg.sv
src/dwrp_mod.sv
src/dwrp_rank.sv
src/draw_without_replacement_picker.sv
src/dwrp_checker.sv
tb/draw_without_replacement_picker_tb.sv
